>>> src/i2cms_pkg.sv
package i2cms_pkg;

  // Command codes carried on the input stream.
  typedef enum logic [2:0] {
    OP_NONE  = 3'd0,
    OP_START = 3'd1,
    OP_STOP  = 3'd2,
    OP_WRITE = 3'd3,
    OP_READ  = 3'd4,
    OP_SACK  = 3'd5,
    OP_RACK  = 3'd6
  } op_t;

  localparam int unsigned OP_W     = 3;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned PHASE_W  = 5;
  localparam int unsigned IN_W     = 16;
  localparam int unsigned OUT_W    = 16;
  localparam logic [1:0]  SUB_LAST = 2'd2;

  // Sequencer state between ticks.
  typedef struct packed {
    op_t                cmd;
    logic [PHASE_W-1:0] phase;
    logic [1:0]         sub;    // position inside one bit slot (three ticks)
    logic [2:0]         bidx;   // bit slot number, MSB first
    logic [BYTE_W-1:0]  shift;
    logic [BYTE_W-1:0]  rxb;
    logic               ack;
    logic               scl;
    logic               sda;
  } seq_state_t;

  // One accepted tick, unpacked from the stream.
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [BYTE_W-1:0] tx_byte;
    logic              ack_level;
    logic              sda_in;
  } tick_t;

  // Number of ticks in each command sequence.
  function automatic logic [PHASE_W-1:0] seq_len(input op_t cmd);
    logic [PHASE_W-1:0] len;
    unique case (cmd)
      OP_START: len = 5'd4;
      OP_STOP:  len = 5'd3;
      OP_WRITE: len = 5'd24;
      OP_READ:  len = 5'd25;
      OP_SACK:  len = 5'd3;
      OP_RACK:  len = 5'd4;
      default:  len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

>>> src/i2c_master_bit_sequencer.sv
// Channel  Direction  Group                      Contents
// input    in         s_tvalid/s_tready/s_tdata  one pin-timing tick, command on s_tuser
// output   out        m_tvalid/m_tready/m_tdata  pin levels and status after that tick
//
// Every cycle one transfer can be accepted on each side; the block sustains one tick per
// clock while m_tready stays high. A tick is held in the input register and is applied
// to the sequencer state on its way into the result register, so its result reaches
// m_tdata through those two registers. The state update for a tick is a single pass of
// short logic. Reset (rst, synchronous, active high) empties both registers, leaves the
// sequencer idle and releases SCL and SDA. A stall on m_tready holds the result register
// and, with it, the input register; s_tready drops only when both are full.
module i2c_master_bit_sequencer (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // [7:0] tx_byte, [8] ack_level, [9] sda_in, [15:10] zero
  input  logic [i2cms_pkg::IN_W-1:0]  s_tdata,
  // [2:0] op
  input  logic [i2cms_pkg::OP_W-1:0]  s_tuser,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // [0] scl_out, [1] sda_out, [2] busy_res, [3] done_res, [11:4] rx_byte,
  // [12] ack_sampled, [15:13] zero
  output logic [i2cms_pkg::OUT_W-1:0] m_tdata
);
  import i2cms_pkg::*;

  logic       in_valid;
  tick_t      in_tick;
  seq_state_t st;
  seq_state_t st_next;
  logic       step_done;
  logic       advance;

  // The held tick moves on when the result register is free or being drained.
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tvalid && s_tready) begin
      in_tick <= '{op: s_tuser, tx_byte: s_tdata[7:0], ack_level: s_tdata[8],
                   sda_in: s_tdata[9]};
    end
  end

  i2cms_step u_step (
    .st      (st),
    .tick    (in_tick),
    .st_next (st_next),
    .done    (step_done)
  );

  // Sequencer state advances exactly once per applied tick.
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '{cmd: OP_NONE, phase: '0, sub: '0, bidx: '0, shift: '0, rxb: '0,
              ack: 1'b0, scl: 1'b1, sda: 1'b1};
    end else if (advance) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (advance) begin
      m_tdata <= {3'b000, st_next.ack, st_next.rxb, step_done,
                  st_next.cmd != OP_NONE, st_next.sda, st_next.scl};
    end
  end

  // A command that just finished cannot still be reported as running.
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[3] && m_tdata[2]))
    else $error("done and busy reported together");

  // An idle sequencer sits at the start of its counters.
  a_idle_counters: assert property (@(posedge clk) disable iff (rst)
    st.cmd == OP_NONE |-> (st.phase == '0 && st.sub == '0 && st.bidx == '0))
    else $error("idle sequencer with counters not cleared");

  // A running command never reaches its own length.
  a_phase_bound: assert property (@(posedge clk) disable iff (rst)
    st.cmd != OP_NONE |-> st.phase < seq_len(st.cmd))
    else $error("sequence phase out of range");

  // State only changes when a tick is applied.
  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(st))
    else $error("sequencer state moved without a tick");

endmodule

>>> src/i2cms_step.sv
module i2cms_step (
  input  i2cms_pkg::seq_state_t st,
  input  i2cms_pkg::tick_t      tick,
  output i2cms_pkg::seq_state_t st_next,
  output logic                  done
);
  import i2cms_pkg::*;

  seq_state_t          s;
  logic [PHASE_W-1:0]  phase_inc;
  logic                bit_step;

  always_comb begin
    s         = st;
    done      = 1'b0;
    phase_inc = '0;
    bit_step  = 1'b0;

    // A new command is taken only while idle; codes outside the list are ignored.
    if (st.cmd == OP_NONE && tick.op >= OP_START && tick.op <= OP_RACK) begin
      s.cmd   = op_t'(tick.op);
      s.phase = '0;
      s.sub   = '0;
      s.bidx  = '0;
      if (tick.op == OP_WRITE) begin
        s.shift = tick.tx_byte;
      end else if (tick.op == OP_SACK) begin
        s.shift = {{(BYTE_W-1){1'b0}}, tick.ack_level};
      end else begin
        s.shift = '0;
      end
    end

    case (s.cmd)
      OP_START: begin
        case (s.phase)
          5'd0:    s.scl = 1'b1;
          5'd1:    s.sda = 1'b1;
          5'd2:    s.sda = 1'b0;
          default: s.scl = 1'b0;
        endcase
      end
      OP_STOP: begin
        case (s.phase)
          5'd0:    s.sda = 1'b0;
          5'd1:    s.scl = 1'b1;
          default: s.sda = 1'b1;
        endcase
      end
      OP_WRITE: begin
        bit_step = 1'b1;
        case (s.sub)
          2'd0: begin
            s.sda   = s.shift[BYTE_W-1];
            s.shift = {s.shift[BYTE_W-2:0], 1'b0};
          end
          2'd1:    s.scl = 1'b1;
          default: s.scl = 1'b0;
        endcase
      end
      OP_READ: begin
        if (s.phase == '0) begin
          s.sda = 1'b1;
        end else begin
          bit_step = 1'b1;
          case (s.sub)
            2'd0: s.scl = 1'b1;
            2'd1: begin
              if (tick.sda_in) begin
                s.shift[~s.bidx] = 1'b1;
              end
            end
            default: s.scl = 1'b0;
          endcase
        end
      end
      OP_SACK: begin
        case (s.phase)
          5'd0:    s.sda = s.shift[0];
          5'd1:    s.scl = 1'b1;
          default: s.scl = 1'b0;
        endcase
      end
      OP_RACK: begin
        case (s.phase)
          5'd0:    s.sda = 1'b1;
          5'd1:    s.scl = 1'b1;
          5'd2:    s.ack = tick.sda_in;
          default: s.scl = 1'b0;
        endcase
      end
      default: begin
      end
    endcase

    // Bit slots are three ticks long; the slot number moves on after the last tick.
    if (bit_step) begin
      if (s.sub == SUB_LAST) begin
        s.sub  = '0;
        s.bidx = s.bidx + 3'd1;
      end else begin
        s.sub = s.sub + 2'd1;
      end
    end

    if (s.cmd != OP_NONE) begin
      phase_inc = s.phase + 5'd1;
      s.phase   = phase_inc;
      if (phase_inc >= seq_len(s.cmd)) begin
        if (s.cmd == OP_READ) begin
          s.rxb = s.shift;
        end
        done    = 1'b1;
        s.cmd   = OP_NONE;
        s.phase = '0;
        s.sub   = '0;
        s.bidx  = '0;
      end
    end

    st_next = s;
  end

endmodule
